// ===== sv/ctp_pkg.sv =====
// ctp_pkg: shared constants and types for the cell-to-point box average block
// no dependencies; used by ctp_seq, ctp_skid and cell_to_point_box_average
package ctp_pkg;

  localparam int MAX_CELLS_X    = 64;
  localparam int MAX_CELLS_Y    = 64;
  localparam int MAX_CELLS_Z    = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int X_W = $clog2(MAX_CELLS_X);
  localparam int Y_W = $clog2(MAX_CELLS_Y);
  localparam int Z_W = $clog2(MAX_CELLS_Z);
  localparam int C_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  // pair, quad and octet sums of samples
  localparam int H_W = SAMPLE_WIDTH + 1;
  localparam int Q_W = SAMPLE_WIDTH + 2;
  localparam int S_W = SAMPLE_WIDTH + 3;

  localparam int ROW_AW    = X_W + C_W;
  localparam int ROW_DEPTH = 2 ** ROW_AW;
  localparam int PLN_AW    = Y_W + X_W + C_W;
  localparam int PLN_DEPTH = 2 ** PLN_AW;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_W      = 7;
  localparam int NC_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COMPONENTS = 3'd3;

  // position of the current cell beat and what it produces
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [C_W-1:0] c;
    logic           emit;
    logic           last;
    logic           three_d;
  } pos_t;

endpackage

// ===== sv/ctp_ram.sv =====
// ctp_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ctp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ctp_seq.sv =====
// ctp_seq: configuration registers and raster position counters
// depends on ctp_pkg
module ctp_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             step,
  output ctp_pkg::pos_t                    pos
);

  localparam int X_W = ctp_pkg::X_W;
  localparam int Y_W = ctp_pkg::Y_W;
  localparam int Z_W = ctp_pkg::Z_W;
  localparam int C_W = ctp_pkg::C_W;

  logic [ctp_pkg::DIM_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [ctp_pkg::NC_W-1:0]  num_components_r;

  logic [X_W-1:0] x_r, x_nxt, xm1;
  logic [Y_W-1:0] y_r, y_nxt, ym1;
  logic [Z_W-1:0] z_r, z_nxt, zm1;
  logic [C_W-1:0] c_r, c_nxt, cm1;

  // last index of each dimension, register values saturated into range
  always_comb begin
    if (cells_x_r < 7'd2) begin
      xm1 = X_W'(1);
    end else if (int'(cells_x_r) > ctp_pkg::MAX_CELLS_X) begin
      xm1 = X_W'(ctp_pkg::MAX_CELLS_X - 1);
    end else begin
      xm1 = X_W'(int'(cells_x_r) - 1);
    end

    if (cells_y_r < 7'd2) begin
      ym1 = Y_W'(1);
    end else if (int'(cells_y_r) > ctp_pkg::MAX_CELLS_Y) begin
      ym1 = Y_W'(ctp_pkg::MAX_CELLS_Y - 1);
    end else begin
      ym1 = Y_W'(int'(cells_y_r) - 1);
    end

    if (cells_z_r == 7'd0) begin
      zm1 = '0;
    end else if (int'(cells_z_r) > ctp_pkg::MAX_CELLS_Z) begin
      zm1 = Z_W'(ctp_pkg::MAX_CELLS_Z - 1);
    end else begin
      zm1 = Z_W'(int'(cells_z_r) - 1);
    end

    if (num_components_r == 3'd0) begin
      cm1 = '0;
    end else if (int'(num_components_r) > ctp_pkg::MAX_COMPONENTS) begin
      cm1 = C_W'(ctp_pkg::MAX_COMPONENTS - 1);
    end else begin
      cm1 = C_W'(int'(num_components_r) - 1);
    end
  end

  // raster advance: component, then x, y, z
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    c_nxt = c_r + C_W'(1);
    if (c_r == cm1) begin
      c_nxt = '0;
      x_nxt = x_r + X_W'(1);
      if (x_r == xm1) begin
        x_nxt = '0;
        y_nxt = y_r + Y_W'(1);
        if (y_r == ym1) begin
          y_nxt = '0;
          z_nxt = (z_r == zm1) ? '0 : z_r + Z_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r        <= 7'd64;
      cells_y_r        <= 7'd64;
      cells_z_r        <= 7'd1;
      num_components_r <= 3'd1;
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
      c_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        ctp_pkg::REG_CELLS_X:        cells_x_r        <= cfg_data;
        ctp_pkg::REG_CELLS_Y:        cells_y_r        <= cfg_data;
        ctp_pkg::REG_CELLS_Z:        cells_z_r        <= cfg_data;
        ctp_pkg::REG_NUM_COMPONENTS: num_components_r <= cfg_data[ctp_pkg::NC_W-1:0];
        default: ;
      endcase
      // any write restarts the block
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
      c_r <= '0;
    end else if (step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      c_r <= c_nxt;
    end
  end

  always_comb begin
    pos.x       = x_r;
    pos.y       = y_r;
    pos.c       = c_r;
    pos.three_d = (zm1 != '0);
    pos.emit    = (x_r != '0) && (y_r != '0) && ((zm1 == '0) || (z_r != '0));
    pos.last    = (x_r == xm1) && (y_r == ym1) && (z_r == zm1) && (c_r == cm1);
  end

endmodule

// ===== sv/ctp_skid.sv =====
// ctp_skid: two-entry output buffer for result beats
// depends on ctp_pkg
module ctp_skid (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [ctp_pkg::SAMPLE_WIDTH-1:0]  push_value,
  input  logic                              push_last,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [ctp_pkg::SAMPLE_WIDTH-1:0]  out_point_value,
  output logic                              out_last_point,
  output logic                              full
);

  logic                             out_valid_r, skid_valid_r;
  logic [ctp_pkg::SAMPLE_WIDTH-1:0] out_value_r, skid_value_r;
  logic                             out_last_r, skid_last_r;
  logic                             pop;

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no push while the skid entry is occupied
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_value_r <= skid_value_r;
        out_last_r  <= skid_last_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_value_r <= push_value;
        out_last_r  <= push_last;
      end else begin
        skid_value_r <= push_value;
        skid_last_r  <= push_last;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_value = out_value_r;
  assign out_last_point  = out_last_r;
  assign full            = skid_valid_r;

endmodule

// ===== sv/cell_to_point_box_average.sv =====
// cell_to_point_box_average: 2x2 / 2x2x2 cell-to-point averaging over one grid block
// depends on ctp_pkg, ctp_ram, ctp_seq, ctp_skid
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | sink      | in_valid/in_stall  | in_cell_value
//   out     | source    | out_valid/out_stall| out_point_value, out_last_point
//   cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one cell beat per clock while in_stall is low; a cell beat is registered in stage 1
// and the point beat it completes then goes to the output buffer; the rate rests on
// the single read-modify-write pass through the row store and the plane store.
// reset restores the default register values and zeroes the raster position;
// the stores are not cleared; a stale entry feeds only beats that are not emitted.
// in_stall rises only while both output entries are held by out_stall.
module cell_to_point_box_average (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ctp_pkg::SAMPLE_WIDTH-1:0]   in_cell_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ctp_pkg::SAMPLE_WIDTH-1:0]   out_point_value,
  output logic                               out_last_point,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW  = ctp_pkg::SAMPLE_WIDTH;
  localparam int H_W = ctp_pkg::H_W;
  localparam int Q_W = ctp_pkg::Q_W;
  localparam int S_W = ctp_pkg::S_W;

  ctp_pkg::pos_t pos;
  logic          accept, en, full;

  // previous cell of the same component, one entry per component
  logic [SW-1:0] prev_r [ctp_pkg::MAX_COMPONENTS];

  logic [H_W-1:0]                 h_nxt;
  logic [ctp_pkg::ROW_AW-1:0]     row_addr;
  logic [ctp_pkg::PLN_AW-1:0]     pln_addr;

  logic                           s1_valid_r;
  logic [H_W-1:0]                 s1_h_r;
  logic [ctp_pkg::ROW_AW-1:0]     s1_row_addr_r;
  logic [ctp_pkg::PLN_AW-1:0]     s1_pln_addr_r;
  logic                           s1_emit_r, s1_last_r, s1_three_d_r;

  logic [H_W-1:0] row_rd;
  logic [Q_W-1:0] pln_rd, q;
  logic [S_W-1:0] sum8;
  logic [SW-1:0]  avg;
  logic           wr_en;

  assign cfg_ready = 1'b1;
  assign en        = !full;
  assign in_stall  = full;
  assign accept    = in_valid && en;

  ctp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .pos       (pos)
  );

  // horizontal pair sum for this cell
  assign h_nxt    = {1'b0, in_cell_value} + {1'b0, prev_r[pos.c]};
  assign row_addr = {pos.x, pos.c};
  assign pln_addr = {pos.y, pos.x, pos.c};

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_r[pos.c] <= in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h_r        <= h_nxt;
      s1_row_addr_r <= row_addr;
      s1_pln_addr_r <= pln_addr;
      s1_emit_r     <= pos.emit;
      s1_last_r     <= pos.last;
      s1_three_d_r  <= pos.three_d;
    end
  end

  // write-back as the beat leaves stage 1; the next read of the same entry is
  // at least one row of beats later
  assign wr_en = s1_valid_r && en;

  // row store: horizontal pair sums of the previous row
  ctp_ram #(
    .WIDTH (H_W),
    .DEPTH (ctp_pkg::ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_row_addr_r),
    .wdata (s1_h_r),
    .re    (accept),
    .raddr (row_addr),
    .rdata (row_rd)
  );

  assign q = {1'b0, s1_h_r} + {1'b0, row_rd};

  // plane store: 2x2 quad sums of the previous plane
  ctp_ram #(
    .WIDTH (Q_W),
    .DEPTH (ctp_pkg::PLN_DEPTH)
  ) u_plane_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_pln_addr_r),
    .wdata (q),
    .re    (accept),
    .raddr (pln_addr),
    .rdata (pln_rd)
  );

  assign sum8 = {1'b0, q} + {1'b0, pln_rd};
  assign avg  = s1_three_d_r ? sum8[S_W-1:3] : q[Q_W-1:2];

  ctp_skid u_skid (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (wr_en && s1_emit_r),
    .push_value      (avg),
    .push_last       (s1_last_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_point_value (out_point_value),
    .out_last_point  (out_last_point),
    .full            (full)
  );

endmodule
